// File: src/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// shared types and codes for the bfs path backtrace block
// ----------------------------------------------------------------------------
`default_nettype none
package bpb_pkg;
    // number of graph nodes held in the tables
    localparam int NODES = 32;

    typedef enum logic [2:0] {
        ACT_SET_EDGE  = 3'd0,
        ACT_SET_DIST  = 3'd1,
        ACT_SET_PAR   = 3'd2,
        ACT_TRACE     = 3'd3,
        ACT_RD_PAR    = 3'd4,
        ACT_RD_DIST   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_HOP,
        ST_EMIT,
        ST_RESTORE,
        ST_FAIL,
        ST_READ
    } t_state;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_START_NODE = 2'd1;
    localparam logic [1:0] REG_END_NODE   = 2'd2;
endpackage
`default_nettype wire

// File: src/bfs_path_backtrace_top.sv
// ----------------------------------------------------------------------------
// bfs_path_backtrace_top
// adjacency, distance and parent store with a backward path trace
// ----------------------------------------------------------------------------
// channel   direction  signals
// input     in         i_valid, o_stall, i_action .. i_distance_value
// output    out        o_valid, i_stall, o_path_node .. o_last
// config    in         apb psel/penable/pwrite/paddr/pwdata/prdata/pready
//
// loads are written on acceptance; reads fetch the value, then load it into the output register.
// a trace first backs up parents and fills path slots, then resolves each hop
// with one row fetch and a scan of all nodes on one shared compare unit, then
// emits the path one transfer at a time.
// a failed trace restores the parent table before it reports the failure.
// synchronous active-low reset; the input is stalled while a trace or a read is
// in progress and while a result waits at a stalled output.
`default_nettype none
module bfs_path_backtrace_top
    import bpb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_action,
    input  wire  [4:0]  i_node_a,
    input  wire  [4:0]  i_node_b,
    input  wire         i_edge_present,
    input  wire  [5:0]  i_distance_value,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [4:0]  o_path_node,
    output logic [5:0]  o_position,
    output logic        o_found,
    output logic [5:0]  o_path_length,
    output logic [15:0] o_paths_found,
    output logic [5:0]  o_read_value,
    output logic        o_last
);
    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [5:0] NMAX = 6'(NODES > 32 ? 32 : NODES);

    // storage; the node at the path end is emitted from the end node register, not a path slot
    logic [NODES-1:0] r_adj [NODES];
    logic [5:0]       r_dist [NODES];
    logic [4:0]       r_par [NODES];
    logic [4:0]       r_bak [NODES];
    logic [4:0]       r_path [NODES];

    logic [5:0]  r_node_count;
    logic [4:0]  r_start, r_end;
    logic [15:0] r_succ;

    t_state      r_state, n_state;
    logic [5:0]  r_d;
    logic [5:0]  r_k;        // slot being resolved
    logic [4:0]  r_v;        // current node
    logic [4:0]  r_target;
    logic [5:0]  r_tdist;
    logic [CW-1:0] r_i;      // scan / sweep index
    logic        r_hit;
    logic [4:0]  r_pick;
    logic [NODES-1:0] r_row;
    logic [5:0]  r_p;

    // effective count
    logic [5:0] w_n;
    assign w_n = (r_node_count > NMAX) ? NMAX : r_node_count;

    function automatic logic in_rng(input logic [4:0] x);
        return 32'(x) < NODES;
    endfunction

    // config port
    logic w_wr;
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_NODE_COUNT: prdata = {26'd0, r_node_count};
            REG_START_NODE: prdata = {27'd0, r_start};
            REG_END_NODE:   prdata = {27'd0, r_end};
            default:        prdata = 32'd0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd32;
            r_start <= 5'd0;
            r_end <= 5'd1;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_NODE_COUNT: r_node_count <= pwdata[5:0];
                REG_START_NODE: r_start <= pwdata[4:0];
                REG_END_NODE:   r_end <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    logic w_acc, w_oacc;
    assign o_stall = (r_state != ST_IDLE) || (o_valid && i_stall);
    assign w_acc = i_valid && !o_stall;
    assign w_oacc = o_valid && !i_stall;

    logic [IW-1:0] w_ai, w_bi, w_ii;
    assign w_ai = w_acc ? i_node_a[IW-1:0] : r_target[IW-1:0];
    assign w_bi = i_node_b[IW-1:0];
    assign w_ii = r_i[IW-1:0];

    // scan compare unit: one neighbour per cycle
    logic [5:0] w_di;
    logic       w_q;
    assign w_di = r_dist[w_ii];
    assign w_q  = (32'(r_i) < 32'(w_n)) && r_row[w_ii] && (r_tdist == w_di + 6'd1);

    logic [4:0] w_pk;
    assign w_pk = (w_q) ? 5'(r_i) : (r_hit ? r_pick : r_end);

    // output register load
    logic w_load;
    assign w_load = (r_state == ST_READ)
                 || (r_state == ST_EMIT && r_v == r_start && (!o_valid || w_oacc)
                     && !(o_valid && o_last))
                 || (r_state == ST_RESTORE && 32'(r_i) == NODES - 1);

    logic [5:0] r_rv;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:
                if (w_acc) begin
                    if (i_action == ACT_TRACE) n_state = ST_INIT;
                    else if (i_action == ACT_RD_PAR || i_action == ACT_RD_DIST)
                        n_state = ST_READ;
                end
            ST_READ:    n_state = ST_IDLE;
            ST_INIT:
                if (32'(r_i) == NODES - 1)
                    n_state = (r_v == r_start || r_d == 6'd0) ? ST_EMIT : ST_HOP;
            ST_HOP:     n_state = ST_SCAN;
            ST_SCAN:
                if (32'(r_i) == NODES - 1) begin
                    if (w_pk == r_start || r_k == 6'd0)
                        n_state = ST_EMIT;
                    else n_state = ST_HOP;
                end
            ST_EMIT:
                if (r_v != r_start) n_state = ST_RESTORE;
                else if (w_oacc && o_last) n_state = ST_IDLE;
            ST_RESTORE: if (32'(r_i) == NODES - 1) n_state = ST_FAIL;
            ST_FAIL:    if (w_oacc) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_succ <= '0;
            o_valid <= 1'b0;
            for (int j = 0; j < NODES; j++) begin
                r_adj[j] <= '0;
                r_dist[j] <= '0;
                r_par[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) o_valid <= 1'b1;
            else if (w_oacc) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE:
                    if (w_acc) begin
                        case (i_action)
                            ACT_SET_EDGE:
                                if (in_rng(i_node_a) && in_rng(i_node_b))
                                    r_adj[w_ai][w_bi] <= i_edge_present;
                            ACT_SET_DIST:
                                if (in_rng(i_node_a))
                                    r_dist[w_ai] <= (i_distance_value > w_n) ? w_n
                                                                            : i_distance_value;
                            ACT_SET_PAR:
                                if (in_rng(i_node_a)) r_par[w_ai] <= i_node_b;
                            ACT_TRACE: begin
                                r_d <= in_rng(r_end) ? r_dist[r_end[IW-1:0]] : 6'd0;
                                r_i <= '0;
                                r_p <= '0;
                                r_v <= r_end;
                            end
                            default: begin
                                r_rv <= !in_rng(i_node_a) ? 6'd0 :
                                        (i_action == ACT_RD_PAR) ? {1'b0, r_par[w_ai]}
                                                                 : r_dist[w_ai];
                            end
                        endcase
                    end
                ST_READ: begin
                    o_path_node <= '0; o_position <= '0; o_found <= 1'b0;
                    o_path_length <= '0; o_paths_found <= r_succ;
                    o_read_value <= r_rv; o_last <= 1'b1;
                end
                ST_INIT: begin
                    // backup parents and fill path slots below the end slot
                    r_bak[w_ii] <= r_par[w_ii];
                    if (r_p < r_d) r_path[r_p[IW-1:0]] <= r_end;
                    if (32'(r_i) == NODES - 1) begin
                        r_p <= '0;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_p < r_d) r_p <= r_p + 6'd1;
                    end
                    r_k <= r_d - 6'd1;
                end
                ST_HOP: begin
                    // the node being resolved is the current node
                    r_target <= r_v;
                    r_tdist <= in_rng(r_v) ? r_dist[r_v[IW-1:0]] : 6'd0;
                    r_row <= in_rng(r_v) ? r_adj[r_v[IW-1:0]] : '0;
                    r_i <= '0;
                    r_hit <= 1'b0;
                end
                ST_SCAN: begin
                    if (w_q) begin
                        r_hit <= 1'b1;
                        r_pick <= 5'(r_i);
                    end
                    if (32'(r_i) == NODES - 1) begin
                        r_path[r_k[IW-1:0]] <= w_pk;
                        if ((r_hit || w_q) && in_rng(r_target))
                            r_par[r_target[IW-1:0]] <= w_pk;
                        r_v <= w_pk;
                        r_k <= r_k - 6'd1;
                        r_p <= '0;
                        r_i <= '0;
                    end else r_i <= r_i + 1'b1;
                end
                ST_EMIT:
                    if (r_v == r_start) begin
                        if (w_load) begin
                            if (r_p == 6'd0 && r_succ != 16'hFFFF)
                                r_succ <= r_succ + 16'd1;
                            o_path_node <= (r_p == r_d) ? r_end : r_path[r_p[IW-1:0]];
                            o_position <= r_p;
                            o_found <= 1'b1;
                            o_path_length <= r_d;
                            o_paths_found <= (r_p == 6'd0 && r_succ != 16'hFFFF)
                                             ? r_succ + 16'd1 : r_succ;
                            o_read_value <= '0;
                            o_last <= (r_p == r_d);
                            r_p <= r_p + 6'd1;
                        end
                    end else r_i <= '0;
                ST_RESTORE: begin
                    r_par[w_ii] <= r_bak[w_ii];
                    r_i <= r_i + 1'b1;
                    if (32'(r_i) == NODES - 1) begin
                        if (in_rng(r_end)) r_dist[r_end[IW-1:0]] <= w_n;
                        o_path_node <= '0; o_position <= '0; o_found <= 1'b0;
                        o_path_length <= '0; o_paths_found <= r_succ;
                        o_read_value <= '0; o_last <= 1'b1;
                    end
                end
                ST_FAIL: ;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
